// ===== hw/rtl/pab_pkg.sv =====
// Shared types, blend mode codes and the rounding function of the premultiplied ARGB blend.
// No dependencies; every file of the block but pab_ifs imports this package.
package pab_pkg;

  // Blend mode codes as held in the mode register.
  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_DARKEN   = 3'd3,
    MODE_LIGHTEN  = 3'd4
  } mode_t;

  localparam int unsigned NUM_CHAN = 3;

  // Full-scale alpha product, 255*255.
  localparam logic [15:0] FULL_SCALE = 16'd65025;

  // Smallest scaled value whose rounded quotient exceeds 255.
  localparam logic [17:0] SAT_LIMIT = 18'd65153;

  localparam logic [16:0] ROUND_BIAS = 17'd127;

  // Products formed in the first stage.
  typedef struct packed {
    logic [15:0]                         alpha_prod; // (255-aa)*(255-ab)
    logic [NUM_CHAN-1:0][7:0]            ca;
    logic [NUM_CHAN-1:0][7:0]            cb;
    logic [NUM_CHAN-1:0][15:0]           pa;         // (255-aa)*cb
    logic [NUM_CHAN-1:0][15:0]           pb;         // (255-ab)*ca
    logic [NUM_CHAN-1:0][15:0]           pab;        // ca*cb
  } prod_t;

  // Scaled values before rounding; lane NUM_CHAN is alpha.
  typedef struct packed {
    logic [NUM_CHAN:0][17:0] x;
  } mix_t;

  // Rounds x/255 to nearest and saturates at 255.
  // The quotient of y by 255 is (y + (y >> 8) + 1) >> 8, exact for y below 65280.
  function automatic logic [7:0] round_sat(input logic [17:0] x);
    logic [16:0] y;
    logic [16:0] t;
    y = {1'b0, x[15:0]} + ROUND_BIAS;
    t = y + {8'd0, y[16:8]} + 17'd1;
    if (x >= SAT_LIMIT) begin
      return 8'hFF;
    end
    return t[15:8];
  endfunction

endpackage

// ===== hw/rtl/pab_ifs.sv =====
// Valid/ready channel interfaces for the pixel pair input and the blended pixel output.
// Depends on nothing; used by the top level of the blend.
interface pab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_pixel;
  logic [31:0] bottom_pixel;

  modport source (output valid, output top_pixel, output bottom_pixel, input ready);
  modport sink   (input valid, input top_pixel, input bottom_pixel, output ready);
endinterface

interface pab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink   (input valid, input result_pixel, output ready);
endinterface

// ===== hw/rtl/premultiplied_argb_blend.sv =====
// Blends a top and a bottom premultiplied ARGB8888 pixel in the mode held in the mode register
// (normal, multiply, screen, darken or lighten) and returns one pixel per input item. The block
// accepts one item in every clock cycle unless the output stalls. One register stage forms the
// 8x8 products, one combines them for the mode, and one rounds and saturates into the output
// register. Each stage holds its item while the next one is full, so a stall at the output
// loses nothing. Write cfg_data with cfg_we only while no item is in flight; writes of codes
// above lighten are ignored. Depends on pab_pkg and pab_ifs.
module premultiplied_argb_blend
  import pab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  pab_in_if.sink      pixel_in,
  pab_out_if.source   pixel_out
);

  mode_t mode;
  logic  s1_valid;
  logic  s1_ready;
  prod_t s1_data;
  logic  s2_valid;
  logic  s2_ready;
  mix_t  s2_data;

  // Mode register; codes beyond lighten leave it unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (cfg_we && (cfg_data <= MODE_LIGHTEN)) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // Product stage.
  pab_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pixel_in.valid),
    .in_ready     (pixel_in.ready),
    .top_pixel    (pixel_in.top_pixel),
    .bottom_pixel (pixel_in.bottom_pixel),
    .out_valid    (s1_valid),
    .out_ready    (s1_ready),
    .out_data     (s1_data)
  );

  // Mode combination stage.
  pab_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Rounding stage and output register.
  pab_round u_round (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s2_valid),
    .in_ready     (s2_ready),
    .in_data      (s2_data),
    .out_valid    (pixel_out.valid),
    .out_ready    (pixel_out.ready),
    .result_pixel (pixel_out.result_pixel)
  );

`ifndef SYNTH
  // An accepted item always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (pixel_in.valid && pixel_in.ready) |=> s1_valid)
    else $error("accepted item did not reach the product stage");

  // A stalled item in the mix stage keeps its place and its value.
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("mix stage item lost or changed during a stall");

  // Out-of-range mode writes leave the mode as it was.
  a_mode_guard: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_data > MODE_LIGHTEN)) |=> $stable(mode))
    else $error("invalid mode code changed the mode register");
`endif

endmodule

// ===== hw/rtl/pab_mul.sv =====
// First pipeline stage: unpacks the pixels and forms all 8x8 products.
// Depends on pab_pkg.
module pab_mul
  import pab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] top_pixel,
  input  logic [31:0] bottom_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output prod_t       out_data
);

  logic  valid;
  prod_t data;
  prod_t data_next;

  // Products for alpha and for each color channel.
  always_comb begin
    logic [7:0] na;
    logic [7:0] nb;
    na = 8'hFF - top_pixel[31:24];
    nb = 8'hFF - bottom_pixel[31:24];
    data_next.alpha_prod = na * nb;
    for (int i = 0; i < NUM_CHAN; i++) begin
      data_next.ca[i]  = top_pixel[8*i +: 8];
      data_next.cb[i]  = bottom_pixel[8*i +: 8];
      data_next.pa[i]  = na * bottom_pixel[8*i +: 8];
      data_next.pb[i]  = nb * top_pixel[8*i +: 8];
      data_next.pab[i] = top_pixel[8*i +: 8] * bottom_pixel[8*i +: 8];
    end
  end

  // The stage takes a new item whenever it is empty or its item moves on.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== hw/rtl/pab_mix.sv =====
// Second pipeline stage: combines the products into the scaled value of the selected mode.
// Depends on pab_pkg.
module pab_mix
  import pab_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  mode_t mode,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output mix_t  out_data
);

  logic valid;
  mix_t data;
  mix_t data_next;

  // Per-channel mode formulas; 255*c is formed as (c << 8) - c.
  always_comb begin
    logic [17:0] sa;
    logic [17:0] sb;
    logic [17:0] pa;
    logic [17:0] pb;
    logic [17:0] pab;
    logic [17:0] p;
    logic [17:0] q;
    data_next.x[NUM_CHAN] = {2'b00, FULL_SCALE - in_data.alpha_prod};
    for (int i = 0; i < NUM_CHAN; i++) begin
      sa  = {2'b00, in_data.ca[i], 8'd0} - {10'd0, in_data.ca[i]};
      sb  = {2'b00, in_data.cb[i], 8'd0} - {10'd0, in_data.cb[i]};
      pa  = {2'b00, in_data.pa[i]};
      pb  = {2'b00, in_data.pb[i]};
      pab = {2'b00, in_data.pab[i]};
      p   = pa + sa;
      q   = pb + sb;
      unique case (mode)
        MODE_MULTIPLY: data_next.x[i] = pa + pb + pab;
        MODE_SCREEN:   data_next.x[i] = sa + sb - pab;
        MODE_DARKEN:   data_next.x[i] = (p < q) ? p : q;
        MODE_LIGHTEN:  data_next.x[i] = (p > q) ? p : q;
        default:       data_next.x[i] = p;
      endcase
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== hw/rtl/pab_round.sv =====
// Third pipeline stage: rounds and saturates each lane and packs the result pixel.
// Depends on pab_pkg; its register is the output register of the block.
module pab_round
  import pab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mix_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_pixel
);

  logic        valid;
  logic [31:0] data;
  logic [31:0] data_next;

  // Alpha goes to the top byte, blue to the bottom one.
  always_comb begin
    for (int i = 0; i <= NUM_CHAN; i++) begin
      data_next[8*i +: 8] = round_sat(in_data.x[i]);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid    = valid;
  assign result_pixel = data;

endmodule

// ===== verif/tb_premultiplied_argb_blend.sv =====
`timescale 1ns / 1ps
// Testbench for the premultiplied ARGB8888 blend: a directed table, then random pixel streams
// checked against an independent blend predictor under shifting stall patterns.
// Depends on pab_pkg, the pab_ifs interfaces and the premultiplied_argb_blend top level.
module tb_premultiplied_argb_blend
  import pab_pkg::*;
();

  // Codes above lighten; the block must ignore writes of these.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES = 3;
  localparam int SEGMENTS_PER_PHASE = 6;
  localparam int ITEMS_PER_SEGMENT = 38;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic [2:0]  mode_code;
    logic [31:0] top;
    logic [31:0] bottom;
    bit          has_value;
    logic [31:0] value;
  } blend_vector_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_data;

  pab_in_if  pixel_in ();
  pab_out_if pixel_out ();

  premultiplied_argb_blend i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out)
  );

  // Blended pixels still owed by the block, oldest first.
  logic [31:0] expected_pixels [$];
  mode_t       mode_shadow;
  logic [2:0]  last_code;
  int          error_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Rows with a value were worked out by hand; the rest go through the predictor.
  blend_vector_t directed_vectors [NUM_DIRECTED] = '{
    '{MODE_NORMAL,   32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{MODE_NORMAL,   32'hFFFFFFFF, 32'h12345678, 1'b1, 32'hFFFFFFFF},
    '{MODE_NORMAL,   32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{MODE_NORMAL,   32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h00FFFFFF},
    '{MODE_NORMAL,   32'h80402010, 32'h40302010, 1'b0, 32'h00000000},
    '{MODE_MULTIPLY, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{MODE_MULTIPLY, 32'h00000000, 32'h80402010, 1'b1, 32'h80402010},
    '{MODE_MULTIPLY, 32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h00FFFFFF},
    '{MODE_MULTIPLY, 32'hC0806040, 32'h80604020, 1'b0, 32'h00000000},
    '{MODE_SCREEN,   32'h00000000, 32'hFF123456, 1'b1, 32'hFF123456},
    '{MODE_SCREEN,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{MODE_SCREEN,   32'h80402010, 32'h80FF00FF, 1'b0, 32'h00000000},
    '{MODE_DARKEN,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
    '{MODE_DARKEN,   32'h80808080, 32'hFF102030, 1'b0, 32'h00000000},
    '{MODE_DARKEN,   32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 32'h00FFFFFF},
    '{MODE_LIGHTEN,  32'h80808080, 32'hFF102030, 1'b0, 32'h00000000},
    '{MODE_LIGHTEN,  32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{MODE_LIGHTEN,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{MODE_RSVD5,    32'h80808080, 32'hFF102030, 1'b0, 32'h00000000},
    '{MODE_RSVD6,    32'h40200000, 32'h80008000, 1'b0, 32'h00000000},
    '{MODE_RSVD7,    32'h7F7F7F7F, 32'h80808080, 1'b0, 32'h00000000},
    '{MODE_NORMAL,   32'h7F7F7F7F, 32'h80808080, 1'b0, 32'h00000000}
  };

  // Divides a scaled value by 255 with rounding to nearest and clamps at 255.
  function automatic logic [7:0] round_to_byte(input int unsigned scaled);
    int unsigned quotient;
    quotient = (scaled + 127) / 255;
    return (quotient > 255) ? 8'hFF : quotient[7:0];
  endfunction

  // Predicts the blended pixel for one pair in the given mode.
  function automatic logic [31:0] blend_pixel(input mode_t mode, input logic [31:0] top,
                                              input logic [31:0] bottom);
    int unsigned aa, ab, ca, cb, over_a, over_b, scaled;
    int lane;
    logic [31:0] pix;
    aa = {24'd0, top[31:24]};
    ab = {24'd0, bottom[31:24]};
    pix = '0;
    pix[31:24] = round_to_byte(65025 - (255 - aa) * (255 - ab));
    for (lane = 0; lane < 3; lane++) begin
      ca = {24'd0, top[8*lane +: 8]};
      cb = {24'd0, bottom[8*lane +: 8]};
      over_a = (255 - aa) * cb + 255 * ca;
      over_b = (255 - ab) * ca + 255 * cb;
      case (mode)
        MODE_MULTIPLY: scaled = (255 - aa) * cb + (255 - ab) * ca + ca * cb;
        MODE_SCREEN:   scaled = 255 * (ca + cb) - ca * cb;
        MODE_DARKEN:   scaled = (over_a < over_b) ? over_a : over_b;
        MODE_LIGHTEN:  scaled = (over_a > over_b) ? over_a : over_b;
        default:       scaled = over_a;
      endcase
      pix[8*lane +: 8] = round_to_byte(scaled);
    end
    return pix;
  endfunction

  // Mostly valid premultiplied pixels, with raw noise and all-or-nothing bytes mixed in.
  function automatic logic [31:0] random_pixel();
    int kind, alpha, lane;
    logic [31:0] pix;
    kind = $urandom_range(9);
    pix = '0;
    if (kind <= 5) begin
      alpha = (kind == 5) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
      pix[31:24] = alpha[7:0];
      for (lane = 0; lane < 3; lane++) begin
        pix[8*lane +: 8] = 8'($urandom_range(alpha));
      end
    end else if (kind <= 7) begin
      pix = $urandom;
    end else begin
      for (lane = 0; lane < 4; lane++) begin
        case ($urandom_range(2))
          0:       pix[8*lane +: 8] = 8'h00;
          1:       pix[8*lane +: 8] = 8'hFF;
          default: pix[8*lane +: 8] = 8'($urandom_range(255));
        endcase
      end
    end
    return pix;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // Offers one pixel pair after a random gap and records its blend once it is taken.
  task automatic send_pixel(input logic [31:0] top, input logic [31:0] bottom,
                            input bit has_value, input logic [31:0] value);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pixel_in.valid <= 1'b0;
      pixel_in.top_pixel <= $urandom;
      pixel_in.bottom_pixel <= $urandom;
      @(negedge clk);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.top_pixel <= top;
    pixel_in.bottom_pixel <= bottom;
    @(posedge clk);
    while (!pixel_in.ready) @(posedge clk);
    expected_pixels.push_back(has_value ? value : blend_pixel(mode_shadow, top, bottom));
  endtask

  // Stops sending and waits until every owed pixel is out and the pipeline is empty.
  task automatic wait_for_drain();
    int cycles;
    cycles = 0;
    @(negedge clk);
    pixel_in.valid <= 1'b0;
    while (expected_pixels.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (expected_pixels.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the mode register; codes above lighten leave the mode as it was.
  task automatic write_mode(input logic [2:0] code);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (code <= MODE_LIGHTEN) begin
      mode_shadow = mode_t'(code);
    end
    last_code = code;
  endtask

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output back-pressure at the current stall rate.
  always @(negedge clk) begin
    pixel_out.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Each pixel taken from the block is matched against the oldest owed pixel.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && pixel_out.valid && pixel_out.ready) begin
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("result %h with nothing owed", pixel_out.result_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out.result_pixel !== want) begin
          report_error($sformatf("result_pixel %h, expected %h",
                                 pixel_out.result_pixel, want));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases with changing stall patterns.
  initial begin
    int idx, phase, seg, item;
    logic [2:0] code;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = MODE_NORMAL;
    pixel_in.valid = 1'b0;
    pixel_in.top_pixel = '0;
    pixel_in.bottom_pixel = '0;
    mode_shadow = MODE_NORMAL;
    last_code = MODE_NORMAL;
    send_idle_pct = 12;
    recv_idle_pct = 46;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first rows run in the mode left by reset.
    for (idx = 0; idx < NUM_DIRECTED; idx++) begin
      if (directed_vectors[idx].mode_code != last_code) begin
        wait_for_drain();
        write_mode(directed_vectors[idx].mode_code);
      end
      send_pixel(directed_vectors[idx].top, directed_vectors[idx].bottom,
                 directed_vectors[idx].has_value, directed_vectors[idx].value);
    end

    // Random segments, each in one mode; every segment boundary drains the pipeline.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        if (seg == 0) begin
          code = (phase == 1) ? MODE_NORMAL : MODE_LIGHTEN;
        end else begin
          code = 3'($urandom_range(7));
        end
        wait_for_drain();
        write_mode(code);
        for (item = 0; item < ITEMS_PER_SEGMENT; item++) begin
          send_pixel(random_pixel(), random_pixel(), 1'b0, '0);
        end
      end
    end

    wait_for_drain();
    if (error_count == 0) begin
      $display("tb_premultiplied_argb_blend: clean");
    end else begin
      $display("tb_premultiplied_argb_blend: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_premultiplied_argb_blend: errors");
    $finish;
  end

endmodule
